// ----- design/dda_line_rasterizer_unit_macros.svh -----
// Assertion macros used by the checker of the line rasterizer.
// They expect clk and arst_n in scope.
`ifndef DDA_LINE_RASTERIZER_UNIT_MACROS_SVH
`define DDA_LINE_RASTERIZER_UNIT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define DLRU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlru check failed");

// antecedent in this cycle implies consequent in the next cycle
`define DLRU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlru check failed");

`endif

// ----- design/dlru_pkg.sv -----
package dlru_pkg;

	localparam int COORD_BITS    = 10;
	localparam int DEF_FRAC_BITS = 16;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
	} cmd_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic                  last_pixel;
	} pix_t;

endpackage

// ----- design/dlru_div.sv -----
module dlru_div #(
	parameter int DIVIDEND_W = 26,
	parameter int DIVISOR_W  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);
	import dlru_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] diff;
	logic               fits;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = ~diff[DIVISOR_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/dda_line_rasterizer_unit.sv -----
// DDA line rasterizer. A load item (mode 0) takes two endpoints, emits the
// first endpoint as a pixel at once and then works out the per-axis
// increments dx*2^FRAC_BITS/steps and dy*2^FRAC_BITS/steps, truncated
// toward zero, where steps = max(|dx|,|dy|). Both divisions run on one
// shared restoring divider, one quotient bit a cycle, x first and y after;
// cmd_stall stays high meanwhile, so a load that draws a real line holds
// off further input until both increments are set. A load with equal
// endpoints emits one pixel flagged last and needs no division. Each
// step item (mode 1) adds the increments to the fixed-point positions
// and emits floor(pos+0.5); the final pixel of the line carries
// last_pixel. A step item while no line is active is accepted and gives
// no result. The result sits in a one-entry output register, so a new
// item is taken while a result waits as long as that register is being
// emptied in the same cycle.
module dda_line_rasterizer_unit #(
	parameter int FRAC_BITS = dlru_pkg::DEF_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  dlru_pkg::cmd_t cmd,
	output logic           pix_valid,
	input  logic           pix_stall,
	output dlru_pkg::pix_t pix
);
	import dlru_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int QW    = C + FRAC_BITS;      // quotient/dividend width
	localparam int POS_W = QW + 1;             // signed position/increment

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIVX = 3'b010,
		ST_DIVY = 3'b100
	} state_t;

	state_t state_q;

	logic signed [POS_W-1:0] x_pos_q, y_pos_q;
	logic signed [POS_W-1:0] x_inc_q, y_inc_q;
	logic [C-1:0]            steps_left_q;
	logic                    line_active_q;
	logic                    x_neg_q, y_neg_q;
	logic [C-1:0]            y_mag_q;
	pix_t                    pix_q;
	logic                    pix_valid_q;

	// handshake
	logic cmd_take, pix_take, is_load, is_step, produce;

	assign cmd_stall = (state_q != ST_IDLE) | (pix_valid_q & pix_stall);
	assign cmd_take  = cmd_valid & ~cmd_stall;
	assign pix_take  = pix_valid_q & ~pix_stall;
	assign is_load   = cmd_take & (cmd.mode == MODE_LOAD);
	assign is_step   = cmd_take & (cmd.mode == MODE_STEP) & line_active_q;
	assign produce   = is_load | is_step;

	// load set-up: deltas, magnitudes, major-axis length
	logic signed [C:0] dx, dy;
	logic [C-1:0]      x_mag, y_mag, steps;

	always_comb begin
		dx    = $signed({1'b0, cmd.x_end}) - $signed({1'b0, cmd.x_start});
		dy    = $signed({1'b0, cmd.y_end}) - $signed({1'b0, cmd.y_start});
		x_mag = dx[C] ? C'(-dx) : dx[C-1:0];
		y_mag = dy[C] ? C'(-dy) : dy[C-1:0];
		steps = (x_mag > y_mag) ? x_mag : y_mag;
	end

	// step path: advance and round to nearest (half up)
	localparam logic signed [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

	logic signed [POS_W-1:0] x_nxt, y_nxt, x_rnd, y_rnd;

	always_comb begin
		x_nxt = x_pos_q + x_inc_q;
		y_nxt = y_pos_q + y_inc_q;
		// positions stay between the endpoints; clamp kept for safety
		x_rnd = x_nxt[POS_W-1] ? HALF : x_nxt + HALF;
		y_rnd = y_nxt[POS_W-1] ? HALF : y_nxt + HALF;
	end

	// shared divider
	logic          div_start, div_done;
	logic [QW-1:0] div_dividend, div_quot;
	logic [C-1:0]  div_divisor;
	logic signed [POS_W-1:0] div_inc;

	assign div_start    = (is_load & (steps != '0)) | ((state_q == ST_DIVX) & div_done);
	assign div_dividend = is_load ? {x_mag, {FRAC_BITS{1'b0}}} : {y_mag_q, {FRAC_BITS{1'b0}}};
	assign div_divisor  = is_load ? steps : steps_left_q;

	dlru_div #(
		.DIVIDEND_W(QW),
		.DIVISOR_W (C)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_comb begin
		div_inc = $signed({1'b0, div_quot});
		if ((state_q == ST_DIVX) ? x_neg_q : y_neg_q)
			div_inc = -div_inc;
	end

	// sequencer and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_active_q <= 1'b0;
			steps_left_q  <= '0;
			x_pos_q       <= '0;
			y_pos_q       <= '0;
			x_inc_q       <= '0;
			y_inc_q       <= '0;
			pix_valid_q   <= 1'b0;
		end else begin
			if (produce)
				pix_valid_q <= 1'b1;
			else if (pix_take)
				pix_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						x_pos_q       <= $signed({1'b0, cmd.x_start, {FRAC_BITS{1'b0}}});
						y_pos_q       <= $signed({1'b0, cmd.y_start, {FRAC_BITS{1'b0}}});
						x_inc_q       <= '0;
						y_inc_q       <= '0;
						steps_left_q  <= steps;
						line_active_q <= (steps != '0);
						if (steps != '0)
							state_q <= ST_DIVX;
					end else if (is_step) begin
						x_pos_q      <= x_nxt;
						y_pos_q      <= y_nxt;
						steps_left_q <= steps_left_q - 1'b1;
						if (steps_left_q == C'(1))
							line_active_q <= 1'b0;
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						x_inc_q <= div_inc;
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						y_inc_q <= div_inc;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (is_load) begin
			x_neg_q <= dx[C];
			y_neg_q <= dy[C];
			y_mag_q <= y_mag;
			pix_q.pixel_x    <= cmd.x_start;
			pix_q.pixel_y    <= cmd.y_start;
			pix_q.last_pixel <= (steps == '0);
		end else if (is_step) begin
			pix_q.pixel_x    <= x_rnd[QW-1:FRAC_BITS];
			pix_q.pixel_y    <= y_rnd[QW-1:FRAC_BITS];
			pix_q.last_pixel <= (steps_left_q == C'(1));
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

// ----- design/dlru_checker.sv -----
`include "dda_line_rasterizer_unit_macros.svh"

module dlru_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input dlru_pkg::cmd_t cmd,
	input logic           pix_valid,
	input logic           pix_stall,
	input dlru_pkg::pix_t pix
);
	import dlru_pkg::*;

	logic load_take, load_flat;
	logic [2*COORD_BITS-1:0] pix_xy, start_xy;

	assign load_take = cmd_valid & ~cmd_stall & (cmd.mode == MODE_LOAD);
	assign load_flat = (cmd.x_start == cmd.x_end) & (cmd.y_start == cmd.y_end);
	assign pix_xy    = {pix.pixel_x, pix.pixel_y};
	assign start_xy  = {cmd.x_start, cmd.y_start};

	`DLRU_ASSERT_NEXT(a_pix_hold, pix_valid && pix_stall, pix_valid)
	`DLRU_ASSERT_NEXT(a_pix_stable, pix_valid && pix_stall, $stable(pix))
	`DLRU_ASSERT_NEXT(a_load_first, load_take, pix_valid && pix_xy == $past(start_xy))
	`DLRU_ASSERT_NEXT(a_load_single, load_take && load_flat, pix.last_pixel && (!cmd_stall || pix_stall))
	`DLRU_ASSERT_NEXT(a_load_busy, load_take && !load_flat, cmd_stall && !pix.last_pixel)

endmodule

bind dda_line_rasterizer_unit dlru_checker u_dlru_checker (.*);
